>>> design/modexp_pkg.sv
// ----------------------------------------------------------------------------
// modexp_pkg
// Constants shared by the modular exponentiation block.
// ----------------------------------------------------------------------------
package modexp_pkg;

  // Width of the base operand. It is fixed by the interface.
  localparam int BASE_BITS = 63;

  // Counter wide enough to walk every base bit.
  localparam int CNT_BITS = $clog2(BASE_BITS);

  // Modulus after reset: the prime 1e9 + 7.
  localparam logic [30:0] MODULUS_RESET = 31'd1000000007;

endpackage

>>> design/modexp_step.sv
// ----------------------------------------------------------------------------
// modexp_step
// One step of interleaved modular multiplication:
// rem_next = (2 * rem + (bit_in ? addend : 0)) mod modulus.
// It needs rem < modulus and addend <= modulus.
// ----------------------------------------------------------------------------
module modexp_step #(
  parameter int MODULUS_BITS = 31
) (
  input  logic [MODULUS_BITS-1:0] modulus,
  input  logic [MODULUS_BITS-1:0] rem,
  input  logic [MODULUS_BITS-1:0] addend,
  input  logic                    bit_in,
  output logic [MODULUS_BITS-1:0] rem_next
);

  localparam int SUM_BITS = MODULUS_BITS + 2;

  logic [SUM_BITS-1:0] sum;
  logic [SUM_BITS-1:0] mod_x1;
  logic [SUM_BITS-1:0] mod_x2;
  logic [SUM_BITS-1:0] reduced;

  always_comb begin
    sum    = {1'b0, rem, 1'b0} + (bit_in ? {2'b00, addend} : '0);
    mod_x1 = {2'b00, modulus};
    mod_x2 = {1'b0, modulus, 1'b0};
    // The sum stays below three times the modulus, so two trial
    // subtractions are enough.
    if (sum >= mod_x2) begin
      reduced = sum - mod_x2;
    end else if (sum >= mod_x1) begin
      reduced = sum - mod_x1;
    end else begin
      reduced = sum;
    end
    rem_next = reduced[MODULUS_BITS-1:0];
  end

endmodule

>>> design/modular_exponentiation_top.sv
// ----------------------------------------------------------------------------
// modular_exponentiation_top
// Computes base_value ** exponent mod modulus by right-to-left square and
// multiply, on one shared bit-serial modular multiplication step.
//
//   Channel   Signals                        Handshake
//   -------   ----------------------------   -------------------------------
//   config    config_write, config_data      written when config_write high
//   input     start, base_value, exponent    accepted when start & !busy
//   result    done, power_result             valid for the one cycle of done
//
// An item first reduces the base (one bit per cycle), then, for each exponent
// bit up to the highest set one, multiplies the result by the running square
// when the bit is set and then squares, and it ends with a final check of
// the exponent. The multiply step sets the pace.
// busy is high from acceptance until done. rst is synchronous and restores
// the modulus to 1000000007. The receiver cannot stall results.
// ----------------------------------------------------------------------------
module modular_exponentiation_top #(
  parameter int MODULUS_BITS  = 31,
  parameter int EXPONENT_BITS = 63
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          config_write,
  input  logic [MODULUS_BITS-1:0]       config_data,
  input  logic                          start,
  output logic                          busy,
  input  logic [modexp_pkg::BASE_BITS-1:0] base_value,
  input  logic [EXPONENT_BITS-1:0]      exponent,
  output logic                          done,
  output logic [MODULUS_BITS-1:0]       power_result
);

  import modexp_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_REDUCE = 3'd1;
  localparam logic [2:0] ST_CHECK  = 3'd2;
  localparam logic [2:0] ST_MUL    = 3'd3;
  localparam logic [2:0] ST_SQR    = 3'd4;

  localparam logic [CNT_BITS-1:0] CNT_BASE = CNT_BITS'(BASE_BITS - 1);
  localparam logic [CNT_BITS-1:0] CNT_MUL  = CNT_BITS'(MODULUS_BITS - 1);
  localparam logic [MODULUS_BITS-1:0] ONE  = MODULUS_BITS'(1);

  logic [2:0]                state;
  logic [MODULUS_BITS-1:0]   modulus;
  logic [MODULUS_BITS-1:0]   mod_item;
  logic [MODULUS_BITS-1:0]   acc;
  logic [MODULUS_BITS-1:0]   sq;
  logic [MODULUS_BITS-1:0]   rem;
  logic [MODULUS_BITS-1:0]   mplier;
  logic [BASE_BITS-1:0]      base_sh;
  logic [EXPONENT_BITS-1:0]  exp_sh;
  logic [CNT_BITS-1:0]       cnt;

  logic [MODULUS_BITS-1:0]   step_addend;
  logic                      step_bit;
  logic [MODULUS_BITS-1:0]   rem_next;

  assign busy = (state != ST_IDLE);

  // During base reduction the step adds one input bit at a time; during a
  // multiplication it adds the running square for each set multiplier bit.
  assign step_addend = (state == ST_REDUCE) ? ONE : sq;
  assign step_bit    = (state == ST_REDUCE) ? base_sh[BASE_BITS-1]
                                            : mplier[MODULUS_BITS-1];

  modexp_step #(
    .MODULUS_BITS(MODULUS_BITS)
  ) u_step (
    .modulus  (mod_item),
    .rem      (rem),
    .addend   (step_addend),
    .bit_in   (step_bit),
    .rem_next (rem_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= MODULUS_BITS'(MODULUS_RESET);
    end else if (config_write) begin
      modulus <= config_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      done <= (state == ST_CHECK) && (exp_sh == '0);
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            // A zero modulus behaves as a modulus of one.
            mod_item <= (modulus == '0) ? ONE : modulus;
            acc      <= ONE;
            rem      <= '0;
            base_sh  <= base_value;
            exp_sh   <= exponent;
            cnt      <= CNT_BASE;
            state    <= ST_REDUCE;
          end
        end
        ST_REDUCE: begin
          rem     <= rem_next;
          base_sh <= base_sh << 1;
          cnt     <= cnt - 1'b1;
          if (cnt == '0) begin
            sq    <= rem_next;
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          rem <= '0;
          cnt <= CNT_MUL;
          if (exp_sh == '0) begin
            power_result <= acc;
            state        <= ST_IDLE;
          end else if (exp_sh[0]) begin
            mplier <= acc;
            state  <= ST_MUL;
          end else begin
            mplier <= sq;
            state  <= ST_SQR;
          end
        end
        ST_MUL: begin
          if (cnt == '0) begin
            acc    <= rem_next;
            rem    <= '0;
            mplier <= sq;
            cnt    <= CNT_MUL;
            state  <= ST_SQR;
          end else begin
            rem    <= rem_next;
            mplier <= mplier << 1;
            cnt    <= cnt - 1'b1;
          end
        end
        ST_SQR: begin
          rem    <= rem_next;
          mplier <= mplier << 1;
          cnt    <= cnt - 1'b1;
          if (cnt == '0) begin
            sq     <= rem_next;
            exp_sh <= exp_sh >> 1;
            state  <= ST_CHECK;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
